// ===== design/text_whitespace_normalizer_assert.svh =====
// Assertion macros for the whitespace normalizer.
// Depends on nothing; included by text_whitespace_normalizer, the module that carries checks.
`ifndef TEXT_WHITESPACE_NORMALIZER_ASSERT_SVH
`define TEXT_WHITESPACE_NORMALIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TWN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TWN_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TWN_ASSERT(lbl, clk, rst_n, prop, msg)
`define TWN_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== design/twn_pkg.sv =====
// Types, byte codes and helpers for the whitespace normalizer.
// Depends on nothing; imported by text_whitespace_normalizer.
`timescale 1ns / 1ps
`default_nettype none

package twn_pkg;

    localparam int HOLD_DEPTH = 32;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W      = $clog2(HOLD_DEPTH);

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    localparam logic [1:0] MODE_UNKNOWN = 2'd0;
    localparam logic [1:0] MODE_LF      = 2'd1;
    localparam logic [1:0] MODE_CRLF    = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       file_done;
        logic       held_overflow;
    } out_word_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_HT) || (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

`default_nettype wire

// ===== design/text_whitespace_normalizer.sv =====
// Whitespace normalizer top level: hold store memory, sequencer, output stage.
// Depends on twn_pkg and text_whitespace_normalizer_assert.svh.
//
//   channel | ports                          | word
//   input   | s_valid, s_ready, s_data       | twn_pkg::in_word_t
//   output  | m_valid, m_ready, m_data       | twn_pkg::out_word_t
//
// A blank byte that fits the hold store is written to it. A content byte first flushes
// the held bytes, one memory read each, and is then sent. A line end runs the line-end
// step; end of file adds the line-end or flush steps, and a full store flushes first.
// Reset clears the sequencer and counters; the hold store needs no clearing.
// A stalled output holds the sequencer; input is taken only in the idle state.
`timescale 1ns / 1ps
`default_nettype none
`include "text_whitespace_normalizer_assert.svh"

module text_whitespace_normalizer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire twn_pkg::in_word_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output twn_pkg::out_word_t       m_data
);
    import twn_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FLUSH = 7'b0000010,
        ST_BYTE  = 7'b0000100,
        ST_STORE = 7'b0001000,
        ST_EOF   = 7'b0010000,
        ST_EOL   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    logic [7:0] held_mem [HOLD_DEPTH];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       mode_reg, mode_next;
    logic [1:0]       run_reg, run_next;
    logic             seen_reg, seen_next;
    logic             last_cr_reg, last_cr_next;
    logic [7:0]       byte_reg, byte_next;
    logic             eof_reg, eof_next;
    logic             ovf_reg, ovf_next;
    logic             content_reg, content_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [7:0]       rd_data_reg;
    logic             cr_sent_reg, cr_sent_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic             pend_ovf_reg, pend_ovf_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        out_reg, out_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             rd_issue;
    logic             push_en;
    logic [7:0]       push_byte;
    logic             push_ovf;
    logic             fin_done;
    logic             out_free;
    logic             can_push;
    logic             cr_before;
    logic [1:0]       mode_eff;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign can_push  = !pend_valid_reg || out_free;
    assign cr_before = (cnt_reg != '0) && last_cr_reg;
    assign mode_eff  = (mode_reg == MODE_UNKNOWN) ? (cr_before ? MODE_CRLF : MODE_LF) : mode_reg;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        mode_next       = mode_reg;
        run_next        = run_reg;
        seen_next       = seen_reg;
        last_cr_next    = last_cr_reg;
        byte_next       = byte_reg;
        eof_next        = eof_reg;
        ovf_next        = ovf_reg;
        content_next    = content_reg;
        rd_idx_next     = rd_idx_reg;
        rd_pend_next    = rd_pend_reg;
        cr_sent_next    = cr_sent_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_ovf_next   = pend_ovf_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[IDX_W-1:0];
        mem_wdata       = s_data.in_byte;
        rd_issue        = 1'b0;
        push_en         = 1'b0;
        push_byte       = byte_reg;
        push_ovf        = 1'b0;
        fin_done        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    byte_next    = s_data.in_byte;
                    eof_next     = s_data.end_of_file;
                    ovf_next     = 1'b0;
                    content_next = 1'b0;
                    rd_idx_next  = '0;
                    rd_pend_next = 1'b0;
                    cr_sent_next = 1'b0;
                    if (s_data.in_byte == CH_LF) begin
                        state_next = ST_EOL;
                    end else if (is_blank(s_data.in_byte)) begin
                        if (cnt_reg == CNT_W'(HOLD_DEPTH)) begin
                            ovf_next   = 1'b1;
                            state_next = ST_FLUSH;
                        end else begin
                            mem_we       = 1'b1;
                            cnt_next     = cnt_reg + CNT_W'(1);
                            last_cr_next = (s_data.in_byte == CH_CR);
                            state_next   = s_data.end_of_file ? ST_EOF : ST_IDLE;
                        end
                    end else begin
                        content_next = 1'b1;
                        state_next   = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                rd_issue = (rd_idx_reg != cnt_reg) && (!rd_pend_reg || can_push);
                if (rd_pend_reg && can_push) begin
                    push_en      = 1'b1;
                    push_byte    = rd_data_reg;
                    push_ovf     = ovf_reg;
                    rd_pend_next = 1'b0;
                end
                if (rd_issue) begin
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                end
                if ((rd_idx_reg == cnt_reg) && !rd_pend_reg) begin
                    if (cnt_reg != '0) begin
                        seen_next = 1'b1;
                        run_next  = 2'd0;
                    end
                    cnt_next = '0;
                    if (ovf_reg) begin
                        state_next = ST_STORE;
                    end else if (content_reg) begin
                        state_next = ST_BYTE;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_BYTE: begin
                if (can_push) begin
                    push_en    = 1'b1;
                    push_byte  = byte_reg;
                    seen_next  = 1'b1;
                    run_next   = 2'd0;
                    state_next = eof_reg ? ST_EOF : ST_FIN;
                end
            end
            ST_STORE: begin
                mem_we       = 1'b1;
                mem_waddr    = '0;
                mem_wdata    = byte_reg;
                cnt_next     = CNT_W'(1);
                last_cr_next = (byte_reg == CH_CR);
                ovf_next     = 1'b0;
                state_next   = eof_reg ? ST_EOF : ST_FIN;
            end
            ST_EOF: begin
                cr_sent_next = 1'b0;
                rd_idx_next  = '0;
                rd_pend_next = 1'b0;
                if (mode_reg != MODE_UNKNOWN) begin
                    state_next = ST_EOL;
                end else if (cnt_reg != '0) begin
                    ovf_next   = 1'b0;
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_EOL: begin
                if (!seen_reg || (run_reg >= 2'd2)) begin
                    mode_next    = mode_eff;
                    cnt_next     = '0;
                    cr_sent_next = 1'b0;
                    state_next   = ST_FIN;
                end else if ((mode_eff == MODE_CRLF) && cr_before && !cr_sent_reg) begin
                    if (can_push) begin
                        push_en      = 1'b1;
                        push_byte    = CH_CR;
                        cr_sent_next = 1'b1;
                    end
                end else if (can_push) begin
                    push_en      = 1'b1;
                    push_byte    = CH_LF;
                    run_next     = run_reg + 2'd1;
                    mode_next    = mode_eff;
                    cnt_next     = '0;
                    cr_sent_next = 1'b0;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN: begin
                if (pend_valid_reg) begin
                    if (out_free) begin
                        out_next.out_byte      = pend_byte_reg;
                        out_next.last_of_run   = 1'b1;
                        out_next.file_done     = eof_reg;
                        out_next.held_overflow = pend_ovf_reg;
                        m_valid_next           = 1'b1;
                        pend_valid_next        = 1'b0;
                        fin_done               = 1'b1;
                        state_next             = ST_IDLE;
                    end
                end else begin
                    fin_done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_en) begin
            if (pend_valid_reg) begin
                out_next.out_byte      = pend_byte_reg;
                out_next.last_of_run   = 1'b0;
                out_next.file_done     = 1'b0;
                out_next.held_overflow = pend_ovf_reg;
                m_valid_next           = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = push_byte;
            pend_ovf_next   = push_ovf;
        end

        if (fin_done && eof_reg) begin
            mode_next = MODE_UNKNOWN;
            cnt_next  = '0;
            run_next  = 2'd0;
            seen_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            held_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_issue) begin
            rd_data_reg <= held_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            mode_reg       <= MODE_UNKNOWN;
            run_reg        <= 2'd0;
            seen_reg       <= 1'b0;
            last_cr_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
            content_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            cr_sent_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            mode_reg       <= mode_next;
            run_reg        <= run_next;
            seen_reg       <= seen_next;
            last_cr_reg    <= last_cr_next;
            ovf_reg        <= ovf_next;
            content_reg    <= content_next;
            rd_idx_reg     <= rd_idx_next;
            rd_pend_reg    <= rd_pend_next;
            cr_sent_reg    <= cr_sent_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        eof_reg       <= eof_next;
        pend_byte_reg <= pend_byte_next;
        pend_ovf_reg  <= pend_ovf_next;
        out_reg       <= out_next;
    end

    `TWN_ASSERT(a_idle_no_pending, aclk, aresetn, (state_reg == ST_IDLE) |-> !pend_valid_reg, "pending word left in idle")
    `TWN_ASSERT(a_read_in_flush, aclk, aresetn, rd_pend_reg |-> (state_reg == ST_FLUSH), "read data outside flush")
    `TWN_NEVER(a_count_range, aclk, aresetn, cnt_reg > CNT_W'(HOLD_DEPTH), "hold count past depth")
    `TWN_ASSERT(a_done_is_last, aclk, aresetn, m_valid_reg |-> (!out_reg.file_done || out_reg.last_of_run), "file_done without last_of_run")
    `TWN_ASSERT(a_eof_clears_mode, aclk, aresetn, (fin_done && eof_reg) |=> (mode_reg == MODE_UNKNOWN), "mode kept after end of file")

endmodule

`default_nettype wire
